/* rtl/tske_pkg.sv */
// Shared types, codes and helper functions for the time set keypad editor.
// Used by every module under rtl; depends on nothing else.
package tske_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 56;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   // item kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // key levels
   localparam logic [1:0] KEY_NONE = 2'd0;
   localparam logic [1:0] KEY_A    = 2'd1;
   localparam logic [1:0] KEY_B    = 2'd2;

   // editable fields
   localparam logic [1:0] FIELD_HOUR   = 2'd0;
   localparam logic [1:0] FIELD_MINUTE = 2'd1;
   localparam logic [1:0] FIELD_SECOND = 2'd2;

   // result events
   localparam logic [1:0] EVENT_NONE = 2'd0;
   localparam logic [1:0] EVENT_SAVE = 2'd1;
   localparam logic [1:0] EVENT_EXIT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK      = 1'b1;

   localparam logic [9:0] LONG_PRESS_RESET = 10'd200;
   localparam logic [7:0] BLINK_RESET      = 8'd50;

   localparam logic [6:0] HOURS_PER_DAY = 7'd24;
   localparam logic [6:0] MINS_PER_HOUR = 7'd60;

   typedef struct packed {
      logic       is_tick;
      logic       key_a;
      logic       key_b;
      logic [5:0] hour;
      logic [6:0] minute;
      logic [6:0] second;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // tens digit masked to 2 bits, units taken as they are
   function automatic logic [5:0] decode_hour(input logic [7:0] bcd);
      logic [5:0] tens;
      tens = {4'b0, bcd[5:4]};
      return (tens << 3) + (tens << 1) + {2'b0, bcd[3:0]};
   endfunction

   // tens digit masked to 3 bits
   function automatic logic [6:0] decode_min_sec(input logic [7:0] bcd);
      logic [6:0] tens;
      tens = {4'b0, bcd[6:4]};
      return (tens << 3) + (tens << 1) + {3'b0, bcd[3:0]};
   endfunction

   // divide by ten through a reciprocal, exact for any 7-bit value
   function automatic logic [7:0] to_bcd(input logic [6:0] value);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  units;
      prod  = value * 15'd205;
      tens  = prod[14:11];
      units = value - ({3'b0, tens} << 3) - ({3'b0, tens} << 1);
      return {tens, units[3:0]};
   endfunction

   // increment modulo a limit; the sum stays below twice the limit
   function automatic logic [6:0] inc_wrap(input logic [6:0] value, input logic [6:0] limit);
      logic [7:0] sum;
      sum = {1'b0, value} + 8'd1;
      if (sum >= {1'b0, limit}) begin
         sum = sum - {1'b0, limit};
      end
      return sum[6:0];
   endfunction

endpackage

/* rtl/tske_front.sv */
// Front end: takes request items, decodes the BCD clock registers and the
// key level, and pushes a command into the queue. Uses tske_pkg.
module tske_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tske_pkg::REQ_DATA_W-1:0]    req_tdata,  // key, hour, minute, second bcd
   input  logic                               req_tuser,  // req_type
   input  tske_pkg::queue_status_type         q_status,
   output logic                               push,
   output tske_pkg::cmd_type                  push_cmd
);
   import tske_pkg::*;

   logic [1:0] key;

   assign key        = req_tdata[1:0];
   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_cmd.is_tick = (req_tuser == REQ_TICK);
      push_cmd.key_a   = (key == KEY_A);
      push_cmd.key_b   = (key == KEY_B);
      push_cmd.hour    = decode_hour(req_tdata[9:2]);
      push_cmd.minute  = decode_min_sec(req_tdata[17:10]);
      push_cmd.second  = decode_min_sec(req_tdata[25:18]);
   end

endmodule

/* rtl/tske_queue.sv */
// Short command queue between the front and back ends.
// Circular buffer of tske_pkg::cmd_type entries with a fill count.
module tske_queue #(
   parameter int DEPTH = tske_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tske_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output tske_pkg::cmd_type          pop_cmd,
   output tske_pkg::queue_status_type status
);
   import tske_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign pop_cmd      = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/tske_back.sv */
// Back end: editor state, blink timer, press counters, settings registers
// and the result register. Uses tske_pkg.
module tske_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tske_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tske_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  cmd_valid,
   input  tske_pkg::cmd_type                     cmd,
   output logic                                  cmd_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tske_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import tske_pkg::*;

   logic [9:0] long_press_ff;
   logic [7:0] blink_ticks_ff;

   logic       active_ff, active_in;
   logic [5:0] hour_ff, hour_in;
   logic [6:0] minute_ff, minute_in;
   logic [6:0] second_ff, second_in;
   logic [1:0] edit_ff, edit_in;
   logic [9:0] press_a_ff, press_a_in;
   logic [9:0] press_b_ff, press_b_in;
   logic       phase_ff, phase_in;
   logic [7:0] blink_count_ff, blink_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [8:0]  blink_next;
   logic [10:0] press_a_next;
   logic [10:0] press_b_next;
   logic        saved;

   logic [5:0] res_hour;
   logic [6:0] res_minute;
   logic [6:0] res_second;
   logic [1:0] res_field;
   logic       res_blank;
   logic [1:0] res_event;
   logic [7:0] res_hour_bcd;
   logic [7:0] res_minute_bcd;
   logic [7:0] res_second_bcd;

   // an item moves on when the result register is free or being drained
   assign cmd_pop    = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign blink_next   = {1'b0, blink_count_ff} + 9'd1;
   assign press_a_next = {1'b0, press_a_ff} + 11'd1;
   assign press_b_next = {1'b0, press_b_ff} + 11'd1;

   always_comb begin
      active_in      = active_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      edit_in        = edit_ff;
      press_a_in     = press_a_ff;
      press_b_in     = press_b_ff;
      phase_in       = phase_ff;
      blink_count_in = blink_count_ff;
      saved          = 1'b0;

      res_hour       = hour_ff;
      res_minute     = minute_ff;
      res_second     = second_ff;
      res_field      = edit_ff;
      res_blank      = 1'b0;
      res_event      = EVENT_NONE;
      res_hour_bcd   = '0;
      res_minute_bcd = '0;
      res_second_bcd = '0;

      if (!cmd.is_tick) begin
         hour_in    = cmd.hour;
         minute_in  = cmd.minute;
         second_in  = cmd.second;
         edit_in    = FIELD_SECOND;
         press_a_in = '0;
         press_b_in = '0;
         active_in  = 1'b1;
         res_hour   = cmd.hour;
         res_minute = cmd.minute;
         res_second = cmd.second;
         res_field  = FIELD_SECOND;
         res_blank  = !phase_ff;
      end else if (active_ff) begin
         res_blank = !phase_ff;

         if (blink_next > {1'b0, blink_ticks_ff}) begin
            blink_count_in = '0;
            phase_in       = !phase_ff;
         end else begin
            blink_count_in = blink_next[7:0];
         end

         if (cmd.key_a) begin
            if (press_a_next > {1'b0, long_press_ff}) begin
               res_event      = EVENT_SAVE;
               res_hour_bcd   = to_bcd({1'b0, hour_ff});
               res_minute_bcd = to_bcd(minute_ff);
               res_second_bcd = to_bcd(second_ff);
               active_in      = 1'b0;
               press_a_in     = '0;
               press_b_in     = '0;
               saved          = 1'b1;
            end else begin
               press_a_in = press_a_next[9:0];
            end
         end else begin
            // short press of key a bumps the selected field
            if (press_a_ff != '0 && press_a_ff < long_press_ff) begin
               case (edit_ff)
                  FIELD_HOUR:   hour_in   = 6'(inc_wrap({1'b0, hour_ff}, HOURS_PER_DAY));
                  FIELD_MINUTE: minute_in = inc_wrap(minute_ff, MINS_PER_HOUR);
                  default:      second_in = inc_wrap(second_ff, MINS_PER_HOUR);
               endcase
            end
            press_a_in = '0;
         end

         // key b is ignored in the tick that saves
         if (!saved) begin
            if (cmd.key_b) begin
               if (press_b_next > {1'b0, long_press_ff}) begin
                  res_event  = EVENT_EXIT;
                  active_in  = 1'b0;
                  press_a_in = '0;
                  press_b_in = '0;
               end else begin
                  press_b_in = press_b_next[9:0];
               end
            end else begin
               if (press_b_ff != '0 && press_b_ff < long_press_ff) begin
                  edit_in = (edit_ff == FIELD_SECOND) ? FIELD_HOUR : edit_ff + 2'd1;
               end
               press_b_in = '0;
            end
         end
      end
   end

   always_comb begin
      rsp_data_in = {7'b0, res_second_bcd, res_minute_bcd, res_hour_bcd, res_event,
                     res_blank, res_field, res_second, res_minute, res_hour};
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff  <= LONG_PRESS_RESET;
         blink_ticks_ff <= BLINK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LONG_PRESS: long_press_ff  <= csr_wdata;
            CSR_BLINK:      blink_ticks_ff <= csr_wdata[7:0];
            default:        long_press_ff  <= long_press_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         hour_ff        <= '0;
         minute_ff      <= '0;
         second_ff      <= '0;
         edit_ff        <= FIELD_SECOND;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         phase_ff       <= 1'b1;
         blink_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd_pop) begin
            active_ff      <= active_in;
            hour_ff        <= hour_in;
            minute_ff      <= minute_in;
            second_ff      <= second_in;
            edit_ff        <= edit_in;
            press_a_ff     <= press_a_in;
            press_b_ff     <= press_b_in;
            phase_ff       <= phase_in;
            blink_count_ff <= blink_count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* rtl/time_set_keypad_editor.sv */
// Top level of the time set keypad editor: front end, command queue, back end.
// Depends on tske_pkg, tske_front, tske_queue and tske_back.
//
// Takes one item per clock cycle without a break while the result side keeps
// up: a load item brings the BCD hour, minute and second, a tick item brings
// the key level, and each gives exactly one result. An accepted item is
// written into the command queue (QUEUE_DEPTH entries); the back end pops it
// when the result register is free or being drained, and its state update
// then loads the result register, which drives the result port. The queue
// lets requests keep flowing for QUEUE_DEPTH items while the result side is
// held; once the queue is full the input resumes in the cycle after the result
// side does. Settings registers may be written at any time the editor is idle;
// csr_ready is always high.
module time_set_keypad_editor #(
   parameter int QUEUE_DEPTH = tske_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // key[1:0], hour_bcd_in[9:2], minute_bcd_in[17:10], second_bcd_in[25:18]
   input  logic [tske_pkg::REQ_DATA_W-1:0]       req_tdata,
   // req_type
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // hour_shown[5:0], minute_shown[12:6], second_shown[19:13],
   // selected_field[21:20], field_blanked[22], event_res[24:23],
   // hour_bcd_out[32:25], minute_bcd_out[40:33], second_bcd_out[48:41]
   output logic [tske_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tske_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tske_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tske_pkg::*;

   queue_status_type q_status;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          pop_cmd;

   tske_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tske_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   tske_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (!q_status.empty),
      .cmd        (pop_cmd),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // an accepted item is held somewhere the cycle after
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !q_status.empty)
      else $error("accepted item lost before the queue");

   // selected field never leaves the three valid codes
   a_field_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21:20] == FIELD_HOUR || rsp_tdata[21:20] == FIELD_MINUTE ||
                      rsp_tdata[21:20] == FIELD_SECOND))
      else $error("selected field out of range");

   // bcd outputs only carry data on a save
   a_bcd_on_save: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[24:23] != EVENT_SAVE) |-> (rsp_tdata[48:25] == '0))
      else $error("bcd result outside a save");

   // queue never pops when empty
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule
